// ----- hw/rtl/dbh_pkg.sv -----
package dbh_pkg;

    // map geometry
    localparam int unsigned MAP_WIDTH  = 512;
    localparam int unsigned MAP_HEIGHT = 512;
    localparam int unsigned CELLS      = MAP_WIDTH * MAP_HEIGHT;
    localparam int unsigned CELL_AW    = $clog2(CELLS);

    // item kinds
    localparam logic KIND_FRAGMENT = 1'b0;
    localparam logic KIND_READ     = 1'b1;

    // merge modes
    localparam logic MERGE_TWO_LAYERS = 1'b0;
    localparam logic MERGE_MAX_ONLY   = 1'b1;

    // gap code
    localparam int unsigned GAP_SHIFT    = 3;
    localparam logic [3:0]  GAP_CODE_MAX = 4'd15;

    typedef enum logic [1:0] {
        REG_MERGE_MODE          = 2'd0,
        REG_HEIGHT_THRESHOLD    = 2'd1,
        REG_MIN_LAYER_THICKNESS = 2'd2,
        REG_MIN_LAYER_GAP       = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic       kind;
        logic [8:0] cell_x;
        logic [8:0] cell_y;
        logic [7:0] frag_height;
        logic [3:0] frag_material;
        logic       from_down_object;
        logic       up_facing;
    } item_t;

    typedef struct packed {
        logic [7:0] low_level;
        logic [7:0] middle_level;
        logic [7:0] high_level;
        logic [3:0] low_mat;
        logic [3:0] high_mat;
        logic       is_double;
        logic [3:0] gap_code;
    } result_t;

    typedef struct packed {
        logic [7:0] low;
        logic [7:0] middle;
        logic [7:0] high;
        logic [3:0] low_mat;
        logic [3:0] high_mat;
    } cell_t;

    typedef struct packed {
        logic       merge_mode;
        logic [7:0] height_threshold;
        logic [7:0] min_layer_thickness;
        logic [7:0] min_layer_gap;
    } cfg_t;

endpackage

// ----- hw/rtl/dbh_ram.sv -----
module dbh_ram #(
    parameter int unsigned DEPTH  = 1024,
    parameter int unsigned ADDR_W = $clog2(DEPTH),
    parameter int unsigned DATA_W = 32
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // read returns the contents from before a write at the same edge
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/dbh_update.sv -----
module dbh_update (
    input  dbh_pkg::cfg_t  cfg,
    input  dbh_pkg::item_t frag,
    input  dbh_pkg::cell_t old_cell,
    output dbh_pkg::cell_t new_cell
);

    always_comb
    begin
        new_cell = old_cell;
        if (frag.frag_height > cfg.height_threshold)
        begin
            if (cfg.merge_mode == dbh_pkg::MERGE_MAX_ONLY || frag.from_down_object)
            begin
                // higher fragment flattens the whole cell
                if (old_cell.high < frag.frag_height)
                begin
                    new_cell.low      = frag.frag_height;
                    new_cell.middle   = frag.frag_height;
                    new_cell.high     = frag.frag_height;
                    new_cell.low_mat  = frag.frag_material;
                    new_cell.high_mat = frag.frag_material;
                end
            end
            else if (frag.up_facing)
            begin
                if (old_cell.high < frag.frag_height)
                begin
                    new_cell.high     = frag.frag_height;
                    new_cell.high_mat = frag.frag_material;
                end
            end
            else if (old_cell.middle < frag.frag_height)
            begin
                new_cell.middle = frag.frag_height;
            end
        end
    end

endmodule

// ----- hw/rtl/dbh_readout.sv -----
module dbh_readout (
    input  dbh_pkg::cfg_t    cfg,
    input  dbh_pkg::cell_t   cell_in,
    output dbh_pkg::result_t result
);

    logic signed [9:0] thick_diff;
    logic signed [9:0] high_gap;
    logic signed [9:0] mid_gap;
    logic              flat;
    logic              thin;
    logic              too_low;
    logic [7:0]        mid_adj;
    logic              gap_close;
    logic              collapse;
    logic [7:0]        low_out;
    logic [7:0]        mid_out;
    logic [8:0]        gap;

    assign flat       = (cell_in.high == cell_in.middle) && (cell_in.middle == cell_in.low);
    assign thick_diff = $signed({2'b00, cell_in.high}) - $signed({2'b00, cell_in.middle});
    assign thin       = thick_diff < $signed({2'b00, cfg.min_layer_thickness});
    assign too_low    = cell_in.high <= cfg.min_layer_thickness;
    assign mid_adj    = (thin && !too_low) ? (cell_in.high - cfg.min_layer_thickness)
                                           : cell_in.middle;

    assign high_gap  = $signed({2'b00, cell_in.high}) - $signed({2'b00, cell_in.low});
    assign mid_gap   = $signed({2'b00, mid_adj}) - $signed({2'b00, cell_in.low});
    assign gap_close = (high_gap < $signed({2'b00, cfg.min_layer_gap}))
                    || (mid_gap < $signed({2'b00, cfg.min_layer_gap}));

    assign collapse = !flat && ((thin && too_low) || gap_close);

    assign low_out = collapse ? cell_in.high : cell_in.low;
    assign mid_out = collapse ? cell_in.high : (flat ? cell_in.middle : mid_adj);

    // borrow in the top bit marks middle below low
    assign gap = {1'b0, mid_out} - {1'b0, low_out};

    always_comb
    begin
        result.low_level    = low_out;
        result.middle_level = mid_out;
        result.high_level   = cell_in.high;
        result.low_mat      = collapse ? cell_in.high_mat : cell_in.low_mat;
        result.high_mat     = cell_in.high_mat;
        result.is_double    = low_out != cell_in.high;
        if (gap[8] || (gap[7:dbh_pkg::GAP_SHIFT] > 5'(dbh_pkg::GAP_CODE_MAX)))
        begin
            result.gap_code = dbh_pkg::GAP_CODE_MAX;
        end
        else
        begin
            result.gap_code = gap[dbh_pkg::GAP_SHIFT+3:dbh_pkg::GAP_SHIFT];
        end
    end

endmodule

// ----- hw/rtl/double_layer_height_buffer.sv -----
// Two-layer height map store. Each map cell holds a low, middle and high
// height and a low and high material in one 32-bit word of a single on-chip
// RAM (one write port, one read port, registered read). A fragment
// transaction reads its cell, merges the fragment and writes the word back;
// a read transaction returns the cell after the thickness and gap fix-up and
// leaves the RAM untouched. Every item issues its RAM read on the edge at
// which it is accepted and moves into the RAM stage, so one item per cycle
// is taken for as long as results are drained; a read result appears on the
// result port at the edge at which the item leaves the RAM stage. An item that
// hits the cell written by the item just before it gets that item's new word
// through a forwarding register, since the RAM read at that edge still sees
// the old contents. The input stalls only during the clearing sweep and while a
// read waits behind a full, stalled result register. After reset the block
// sweeps all MAP_WIDTH * MAP_HEIGHT cells (262144 for the 512 x 512 map) of the
// RAM to zero, one cell a cycle; no item is accepted during that sweep,
// configuration writes are. Configuration must only change while no item is
// in flight.

module double_layer_height_buffer (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                item_valid,
    output logic                item_stall,
    input  dbh_pkg::item_t      item,

    output logic                result_valid,
    input  logic                result_stall,
    output dbh_pkg::result_t    result,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  dbh_pkg::cfg_index_t cfg_index,
    input  logic [7:0]          cfg_data
);

    localparam int unsigned AW = dbh_pkg::CELL_AW;

    // configuration registers
    dbh_pkg::cfg_t    cfg_reg;

    // clearing sweep after reset
    logic             clr_active_reg;
    logic [AW-1:0]    clr_addr_reg;

    // address of the incoming item
    logic [31:0]      item_index;
    logic             item_inside;
    logic [AW-1:0]    item_addr;
    logic             item_accept;

    // ram stage: item whose cell word is being read
    logic             s1_valid_reg;
    dbh_pkg::item_t   s1_item_reg;
    logic             s1_inside_reg;
    logic [AW-1:0]    s1_addr_reg;

    // last write that coincided with an item's ram read
    logic             fwd_valid_reg;
    logic [AW-1:0]    fwd_addr_reg;
    dbh_pkg::cell_t   fwd_cell_reg;

    // ram ports
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    dbh_pkg::cell_t   wr_cell;
    dbh_pkg::cell_t   ram_cell;

    dbh_pkg::cell_t   old_cell;
    dbh_pkg::cell_t   new_cell;
    dbh_pkg::cell_t   read_cell;
    dbh_pkg::result_t fixed_result;

    logic             frag_write;
    logic             s1_is_read;
    logic             out_free;
    logic             result_load;

    // result register
    logic             result_valid_reg;
    dbh_pkg::result_t result_reg;

    // ---------------------------------------------------------------
    // configuration: always ready, a write lands at once
    // ---------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dbh_pkg::REG_MERGE_MODE:          cfg_reg.merge_mode          <= cfg_data[0];
                dbh_pkg::REG_HEIGHT_THRESHOLD:    cfg_reg.height_threshold    <= cfg_data;
                dbh_pkg::REG_MIN_LAYER_THICKNESS: cfg_reg.min_layer_thickness <= cfg_data;
                dbh_pkg::REG_MIN_LAYER_GAP:       cfg_reg.min_layer_gap       <= cfg_data;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // cell address: column plus row times map width
    // ---------------------------------------------------------------
    assign item_index  = 32'(item.cell_x) + 32'(dbh_pkg::MAP_WIDTH) * 32'(item.cell_y);
    assign item_inside = (32'(item.cell_x) < 32'(dbh_pkg::MAP_WIDTH))
                      && (32'(item.cell_y) < 32'(dbh_pkg::MAP_HEIGHT));
    assign item_addr   = item_index[AW-1:0];

    // ---------------------------------------------------------------
    // flow control
    // ---------------------------------------------------------------
    assign s1_is_read  = s1_valid_reg && (s1_item_reg.kind == dbh_pkg::KIND_READ);
    assign out_free    = !result_valid_reg || !result_stall;
    assign result_load = s1_is_read && out_free;

    // a fragment always leaves the ram stage; a read waits for the result slot
    assign item_stall  = clr_active_reg || (s1_is_read && !out_free);
    assign item_accept = item_valid && !item_stall;

    // ---------------------------------------------------------------
    // clearing sweep
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            if (clr_addr_reg == AW'(dbh_pkg::CELLS - 1))
            begin
                clr_active_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    // ---------------------------------------------------------------
    // ram stage registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else if (item_accept)
        begin
            s1_valid_reg  <= 1'b1;
            // the write at this edge is invisible to the read issued now
            fwd_valid_reg <= frag_write;
        end
        else if (!s1_is_read || out_free)
        begin
            s1_valid_reg  <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            s1_item_reg   <= item;
            s1_inside_reg <= item_inside;
            s1_addr_reg   <= item_addr;
            fwd_addr_reg  <= s1_addr_reg;
            fwd_cell_reg  <= new_cell;
        end
    end

    // ---------------------------------------------------------------
    // cell memory
    // ---------------------------------------------------------------
    dbh_ram #(
        .DEPTH  (dbh_pkg::CELLS),
        .ADDR_W (AW),
        .DATA_W ($bits(dbh_pkg::cell_t))
    ) u_cell_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_cell),
        .rd_en   (item_accept),
        .rd_addr (item_addr),
        .rd_data (ram_cell)
    );

    assign old_cell = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_cell_reg
                                                                         : ram_cell;

    // ---------------------------------------------------------------
    // fragment merge and write back
    // ---------------------------------------------------------------
    dbh_update u_update (
        .cfg      (cfg_reg),
        .frag     (s1_item_reg),
        .old_cell (old_cell),
        .new_cell (new_cell)
    );

    assign frag_write = s1_valid_reg && (s1_item_reg.kind == dbh_pkg::KIND_FRAGMENT)
                     && s1_inside_reg;

    assign wr_en   = clr_active_reg || frag_write;
    assign wr_addr = clr_active_reg ? clr_addr_reg : s1_addr_reg;
    assign wr_cell = clr_active_reg ? dbh_pkg::cell_t'('0) : new_cell;

    // ---------------------------------------------------------------
    // readout fix-up; a cell off the map reads as all zero
    // ---------------------------------------------------------------
    assign read_cell = s1_inside_reg ? old_cell : dbh_pkg::cell_t'('0);

    dbh_readout u_readout (
        .cfg     (cfg_reg),
        .cell_in (read_cell),
        .result  (fixed_result)
    );

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (result_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            result_reg <= fixed_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ----- hw/rtl/dbh_checker.sv -----
module dbh_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_stall,
    input dbh_pkg::item_t   item,
    input logic             result_valid,
    input logic             result_stall,
    input dbh_pkg::result_t result
);

    logic read_accept;
    logic frag_accept;

    assign read_accept = item_valid && !item_stall && (item.kind == dbh_pkg::KIND_READ);
    assign frag_accept = item_valid && !item_stall && (item.kind == dbh_pkg::KIND_FRAGMENT);

    // stalled result transaction holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // a fresh result traces back to an accepted read
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(read_accept, 2))
        else $error("result without a read transaction");

    // a fragment never raises a result
    a_no_frag_result: assert property (@(posedge clk) disable iff (!rst_n)
        $past(frag_accept, 2) && !$past(result_valid) |-> !result_valid)
        else $error("fragment produced a result");

    // a read in the ram stage behind a blocked result holds the input
    a_read_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        $past(read_accept) && result_valid && result_stall |-> item_stall)
        else $error("item taken while a read waits for the result slot");

endmodule

bind double_layer_height_buffer dbh_checker u_dbh_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

// ----- bench/tb_top.sv -----
module tb_top;

    // slowest run: the clearing sweep of every cell after reset, then about 1250
    // transactions with random idling on both sides each, plus long receiver hold-offs
    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    // cycles a fragment may still be in flight once the last read result is back
    localparam int          DRAIN_CYCLES = 8;
    localparam int          POOL_SIZE    = 16;
    localparam int          REPORT_LINES = 100;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;

    logic                item_valid = 1'b0;
    logic                item_stall;
    dbh_pkg::item_t      item = '0;

    logic                result_valid;
    logic                result_stall = 1'b0;
    dbh_pkg::result_t    result;

    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    dbh_pkg::cfg_index_t cfg_index = dbh_pkg::REG_MERGE_MODE;
    logic [7:0]          cfg_data = '0;

    // predicted contents of the map, sparse since only a few cells are touched
    dbh_pkg::cell_t      cell_state [int unsigned];
    dbh_pkg::cfg_t       model_cfg = '0;
    dbh_pkg::result_t    pending_reads [$];

    // stimulus shaping
    bit          no_idle = 1'b0;
    logic        hold_on = 1'b0;
    int          stall_left = 0;
    logic [8:0]  pool_x [POOL_SIZE];
    logic [8:0]  pool_y [POOL_SIZE];

    // bookkeeping
    int unsigned cycle_count = 0;
    int          mismatches = 0;
    int          items_sent = 0;
    int          reads_checked = 0;
    int          settings_used = 0;

    double_layer_height_buffer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor of the height store
    // ------------------------------------------------------------------

    function automatic int unsigned cell_addr(dbh_pkg::item_t it);
        return int'(it.cell_x) + dbh_pkg::MAP_WIDTH * int'(it.cell_y);
    endfunction

    function automatic dbh_pkg::cell_t stored_cell(dbh_pkg::item_t it);
        int unsigned addr;
        addr = cell_addr(it);
        if (cell_state.exists(addr))
        begin
            return cell_state[addr];
        end
        return '0;
    endfunction

    // fold one fragment into the predicted cell
    function automatic void merge_fragment(dbh_pkg::item_t it);
        dbh_pkg::cell_t c;
        c = stored_cell(it);
        if (it.frag_height <= model_cfg.height_threshold)
        begin
            return;
        end
        if (model_cfg.merge_mode == dbh_pkg::MERGE_MAX_ONLY || it.from_down_object)
        begin
            // a taller surface swallows the whole column
            if (c.high < it.frag_height)
            begin
                c.low      = it.frag_height;
                c.middle   = it.frag_height;
                c.high     = it.frag_height;
                c.low_mat  = it.frag_material;
                c.high_mat = it.frag_material;
            end
        end
        else if (it.up_facing)
        begin
            if (c.high < it.frag_height)
            begin
                c.high     = it.frag_height;
                c.high_mat = it.frag_material;
            end
        end
        else if (c.middle < it.frag_height)
        begin
            c.middle = it.frag_height;
        end
        cell_state[cell_addr(it)] = c;
    endfunction

    // what a read of the cell returns after the thickness and gap fix-up
    function automatic dbh_pkg::result_t fixed_up_cell(dbh_pkg::item_t it);
        dbh_pkg::cell_t   c;
        dbh_pkg::result_t r;
        int               lo;
        int               mid;
        int               hi;
        int               thick;
        int               min_gap;
        int               span;
        logic [3:0]       lmat;
        bit               collapse;
        c       = stored_cell(it);
        lo      = int'(c.low);
        mid     = int'(c.middle);
        hi      = int'(c.high);
        lmat    = c.low_mat;
        thick   = int'(model_cfg.min_layer_thickness);
        min_gap = int'(model_cfg.min_layer_gap);
        // a flat cell passes through untouched
        if (!(hi == mid && mid == lo))
        begin
            collapse = 1'b0;
            if (hi - mid < thick)
            begin
                // upper layer too thin: push middle down, or give up on two layers
                if (hi - thick <= 0)
                begin
                    collapse = 1'b1;
                end
                else
                begin
                    mid = hi - thick;
                end
            end
            if (!collapse && (hi - lo < min_gap || mid - lo < min_gap))
            begin
                collapse = 1'b1;
            end
            if (collapse)
            begin
                lo   = hi;
                mid  = hi;
                lmat = c.high_mat;
            end
        end
        span           = mid - lo;
        r.low_level    = 8'(lo);
        r.middle_level = 8'(mid);
        r.high_level   = 8'(hi);
        r.low_mat      = lmat;
        r.high_mat     = c.high_mat;
        r.is_double    = (lo != hi);
        // middle below low also saturates
        if (span < 0 || (span >> dbh_pkg::GAP_SHIFT) > int'(dbh_pkg::GAP_CODE_MAX))
        begin
            r.gap_code = dbh_pkg::GAP_CODE_MAX;
        end
        else
        begin
            r.gap_code = 4'(span >> dbh_pkg::GAP_SHIFT);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, int got, int want);
        if (mismatches < REPORT_LINES)
        begin
            $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got,
                     want);
        end
        mismatches++;
    endtask

    task automatic compare_field(string what, logic [7:0] got, logic [7:0] want);
        if (got !== want)
        begin
            report_mismatch(what, int'(got), int'(want));
        end
    endtask

    // every accepted result is matched against the oldest outstanding read
    always @(posedge clk)
    begin : check_results
        dbh_pkg::result_t want;
        if (rst_n && result_valid === 1'b1 && !result_stall)
        begin
            if (pending_reads.size() == 0)
            begin
                report_mismatch("result with no read outstanding, high level",
                                int'(result.high_level), 0);
            end
            else
            begin
                want = pending_reads.pop_front();
                compare_field("low_level", result.low_level, want.low_level);
                compare_field("middle_level", result.middle_level, want.middle_level);
                compare_field("high_level", result.high_level, want.high_level);
                compare_field("low_mat", 8'(result.low_mat), 8'(want.low_mat));
                compare_field("high_mat", 8'(result.high_mat), 8'(want.high_mat));
                compare_field("is_double", 8'(result.is_double), 8'(want.is_double));
                compare_field("gap_code", 8'(result.gap_code), 8'(want.gap_code));
                reads_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver side: random stall after each result, plus the long hold-off
    // ------------------------------------------------------------------

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 9);
    endfunction

    always @(posedge clk)
    begin
        if (result_valid === 1'b1 && !result_stall)
        begin
            stall_left = draw_wait();
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
        end
        result_stall <= hold_on || (stall_left > 0);
    end

    // keeps the result port blocked for a counted stretch
    task automatic hold_results(int cycles);
        hold_on <= 1'b1;
        repeat (cycles) @(posedge clk);
        hold_on <= 1'b0;
    endtask

    // overall time limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("run did not finish within %0d cycles", CYCLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // valid is left high after acceptance so that back-to-back transactions never
    // lower and raise it in the same step; anything that pauses lowers it first
    task automatic send_item(dbh_pkg::item_t it);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        items_sent++;
        if (it.kind == dbh_pkg::KIND_READ)
        begin
            pending_reads.push_back(fixed_up_cell(it));
        end
        else
        begin
            merge_fragment(it);
        end
    endtask

    function automatic dbh_pkg::item_t make_item(logic kind, int x, int y, int height,
                                                 int mat, logic down, logic up);
        dbh_pkg::item_t it;
        it.kind             = kind;
        it.cell_x           = 9'(x);
        it.cell_y           = 9'(y);
        it.frag_height      = 8'(height);
        it.frag_material    = 4'(mat);
        it.from_down_object = down;
        it.up_facing        = up;
        return it;
    endfunction

    task automatic send_fragment(int x, int y, int height, int mat, logic down, logic up);
        send_item(make_item(dbh_pkg::KIND_FRAGMENT, x, y, height, mat, down, up));
    endtask

    // fragment fields are junk on a read
    task automatic send_read(int x, int y);
        send_item(make_item(dbh_pkg::KIND_READ, x, y, int'($urandom), int'($urandom),
                            1'($urandom), 1'($urandom)));
    endtask

    // wait until no read is outstanding and any trailing fragment has retired
    task automatic settle_block();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_reads.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic dbh_pkg::cfg_t settings(logic mode, logic [7:0] thr,
                                               logic [7:0] thick, logic [7:0] gap);
        dbh_pkg::cfg_t s;
        s.merge_mode          = mode;
        s.height_threshold    = thr;
        s.min_layer_thickness = thick;
        s.min_layer_gap       = gap;
        return s;
    endfunction

    // all four registers, back to back, only once the block is quiet
    task automatic apply_settings(dbh_pkg::cfg_t s);
        dbh_pkg::cfg_index_t idx;
        logic [7:0]          val;
        settle_block();
        for (int i = 0; i < 4; i++)
        begin
            idx = dbh_pkg::cfg_index_t'(i);
            case (idx)
                dbh_pkg::REG_MERGE_MODE:          val = {7'd0, s.merge_mode};
                dbh_pkg::REG_HEIGHT_THRESHOLD:    val = s.height_threshold;
                dbh_pkg::REG_MIN_LAYER_THICKNESS: val = s.min_layer_thickness;
                default:                          val = s.min_layer_gap;
            endcase
            cfg_index <= idx;
            cfg_data  <= val;
            cfg_valid <= 1'b1;
            @(posedge clk);
            while (!cfg_ready)
            begin
                @(posedge clk);
            end
        end
        cfg_valid <= 1'b0;
        model_cfg = s;
        settings_used++;
    endtask

    // a handful of cells that random traffic keeps hitting, two of them corners
    task automatic new_cell_pool();
        pool_x[0] = '0;
        pool_y[0] = '0;
        pool_x[1] = '1;
        pool_y[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
        begin
            pool_x[i] = 9'($urandom);
            pool_y[i] = 9'($urandom);
        end
    endtask

    function automatic dbh_pkg::item_t draw_item(int read_percent);
        dbh_pkg::item_t it;
        int             slot;
        slot    = $urandom_range(0, POOL_SIZE - 1);
        it.kind = ($urandom_range(0, 99) < read_percent) ? dbh_pkg::KIND_READ
                                                          : dbh_pkg::KIND_FRAGMENT;
        if ($urandom_range(0, 6) == 0)
        begin
            it.cell_x = 9'($urandom);
            it.cell_y = 9'($urandom);
        end
        else
        begin
            it.cell_x = pool_x[slot];
            it.cell_y = pool_y[slot];
        end
        // half the heights sit at or just above the threshold so cells do not all saturate
        if ($urandom_range(0, 1) == 1)
        begin
            it.frag_height = 8'($urandom);
        end
        else
        begin
            it.frag_height = 8'(int'(model_cfg.height_threshold) + $urandom_range(0, 40));
        end
        it.frag_material    = 4'($urandom);
        it.from_down_object = ($urandom_range(0, 4) == 0);
        it.up_facing        = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // untouched cell, corner cells, all-extreme fragment, height at threshold
    task automatic test_empty_map_and_corners();
        apply_settings(settings(dbh_pkg::MERGE_TWO_LAYERS, 8'd0, 8'd0, 8'd0));
        send_read(0, 0);
        send_fragment(0, 0, 0, 15, 1'b1, 1'b1);
        send_fragment(511, 511, 255, 15, 1'b1, 1'b1);
        send_read(511, 511);
        // middle above high with zero thickness collapses onto high
        send_fragment(0, 511, 1, 0, 1'b0, 1'b0);
        send_read(0, 511);
    endtask

    // up faces raise the top, others the middle; thin upper layer, close layers
    task automatic test_two_layer_merge();
        apply_settings(settings(dbh_pkg::MERGE_TWO_LAYERS, 8'd10, 8'd8, 8'd16));
        send_fragment(100, 200, 200, 7, 1'b0, 1'b1);
        send_fragment(100, 200, 60, 3, 1'b0, 1'b0);
        send_read(100, 200);
        send_fragment(100, 200, 195, 3, 1'b0, 1'b0);
        send_fragment(100, 200, 10, 9, 1'b0, 1'b1);
        send_fragment(100, 200, 150, 9, 1'b1, 1'b0);
        send_read(100, 200);
        // top only 12 above the floor, closer than the gap: reads as one layer
        send_fragment(3, 4, 12, 6, 1'b0, 1'b1);
        send_read(3, 4);
    endtask

    // thickness larger than the top: collapse; middle pushed below low
    task automatic test_thin_and_close_layers();
        apply_settings(settings(dbh_pkg::MERGE_TWO_LAYERS, 8'd0, 8'd255, 8'd0));
        send_read(100, 200);
        apply_settings(settings(dbh_pkg::MERGE_TWO_LAYERS, 8'd0, 8'd100, 8'd0));
        send_fragment(7, 300, 50, 2, 1'b1, 1'b0);
        send_fragment(7, 300, 120, 5, 1'b0, 1'b1);
        send_read(7, 300);
    endtask

    task automatic test_take_max_merge();
        apply_settings(settings(dbh_pkg::MERGE_MAX_ONLY, 8'd0, 8'd0, 8'd0));
        send_fragment(511, 0, 80, 3, 1'b0, 1'b1);
        send_fragment(511, 0, 70, 4, 1'b0, 1'b1);
        send_fragment(511, 0, 90, 9, 1'b0, 1'b0);
        send_read(511, 0);
    endtask

    // results blocked for a long stretch while reads keep coming: the block fills
    task automatic test_backpressure();
        apply_settings(settings(dbh_pkg::MERGE_TWO_LAYERS, 8'd0, 8'd4, 8'd4));
        new_cell_pool();
        no_idle = 1'b1;
        fork
            hold_results(300);
        join_none
        for (int i = 0; i < 80; i++)
        begin
            send_item(draw_item(70));
        end
        no_idle = 1'b0;
    endtask

    // phases of random traffic, each with its own register setting and fresh cells
    task automatic test_random_phases();
        dbh_pkg::cfg_t  s;
        dbh_pkg::item_t it;
        int             counted;
        int             target;
        int             n;
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: s = settings(dbh_pkg::MERGE_TWO_LAYERS, 8'd0, 8'd0, 8'd0);
                1: s = settings(dbh_pkg::MERGE_MAX_ONLY, 8'd0, 8'd0, 8'd0);
                2: s = settings(dbh_pkg::MERGE_TWO_LAYERS, 8'd255, 8'd255, 8'd255);
                3: s = settings(dbh_pkg::MERGE_TWO_LAYERS, 8'd0, 8'd255, 8'd255);
                default: s = settings(1'($urandom_range(0, 1)), 8'($urandom_range(0, 60)),
                                      8'($urandom_range(0, 40)), 8'($urandom_range(0, 40)));
            endcase
            // every fragment is dropped at the top threshold, so keep that phase short
            target = (p == 2) ? 40 : 140;
            apply_settings(s);
            new_cell_pool();
            counted = 0;
            n       = 0;
            while (counted < target)
            begin
                // stretches at full rate on both sides now and then
                if (n % 40 == 0)
                begin
                    no_idle = ($urandom_range(0, 3) == 0);
                end
                it = draw_item(30);
                send_item(it);
                if (it.kind == dbh_pkg::KIND_READ || it.frag_height > s.height_threshold)
                begin
                    counted++;
                end
                n++;
            end
            no_idle = 1'b0;
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_map_and_corners();
        test_two_layer_merge();
        test_thin_and_close_layers();
        test_take_max_merge();
        test_backpressure();
        test_random_phases();

        settle_block();
        $display("%0d transactions sent, %0d read results checked, %0d register settings",
                 items_sent, reads_checked, settings_used);
        $display("covered both merge modes, thresholds, layer fix-ups and a long stall");
        if (mismatches == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
